// ===== rtl/cfr_pkg.sv =====
`default_nettype none
package cfr_pkg;

  // Working formats: angle terms in Q.20, quotients in Q.30
  localparam int unsigned WB   = 20;
  localparam int unsigned QB   = 30;
  localparam int unsigned CW   = 21;  // c, cos2, sin2 (up to 1.0 in Q.20)
  localparam int unsigned NREG = 3;   // channels that have registers

  // Channel pipeline depth, front stage to registered result
  localparam int unsigned CH_LAT = 98;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_ETA_RED,
    CFG_ETA_GREEN,
    CFG_ETA_BLUE,
    CFG_ABSORB_RED,
    CFG_ABSORB_GREEN,
    CFG_ABSORB_BLUE
  } cfg_idx_t;

  // Shared angle terms handed to every channel
  typedef struct packed {
    logic          vld;
    logic [CW-1:0] c;
    logic [CW-1:0] cos2;
    logic [CW-1:0] sin2;
  } front_t;

endpackage
`default_nettype wire

// ===== rtl/cfr_channel.sv =====
`default_nettype none
module cfr_channel #(
  parameter int FRAC_BITS = 15
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire cfr_pkg::front_t fr,
  input  wire logic [15:0]    eta,
  input  wire logic [15:0]    absorb,
  output logic                vld_o,
  output logic [15:0]         refl_o
);
  import cfr_pkg::*;

  localparam int unsigned R1 = 30;      // root bits of S
  localparam int unsigned R2 = 25;      // root bits of a
  localparam int unsigned RW1 = R1 + 4;
  localparam int unsigned RW2 = R2 + 4;
  localparam int unsigned DQ = 31;      // quotient bits
  localparam int unsigned SH = QB - FRAC_BITS;
  localparam logic [32:0] ONE = 33'd1 << FRAC_BITS;
  localparam logic [32:0] RND_OUT = 33'd1 << (SH - 1);

  typedef struct packed {
    logic signed [29:0] d;
    logic [CW-1:0]      c;
    logic [CW-1:0]      cos2;
    logic [CW-1:0]      sin2;
  } sd1_t;

  typedef struct packed {
    logic [29:0]   s;
    logic [CW-1:0] c;
    logic [CW-1:0] cos2;
    logic [CW-1:0] sin2;
  } sd2_t;

  // Stage 1: squares of eta and k, Q.24 rounded to Q.20
  logic          p1_vld_r;
  logic [27:0]   p1_eta2_r, p1_k2_r;
  logic [CW-1:0] p1_c_r, p1_cos2_r, p1_sin2_r;
  logic [31:0]   eta_sq, k_sq;

  assign eta_sq = eta * eta;
  assign k_sq   = absorb * absorb;

  always_ff @(posedge clk) begin
    if (!rst_n) p1_vld_r <= 1'b0;
    else p1_vld_r <= fr.vld;
    p1_eta2_r <= 28'((33'(eta_sq) + 33'd8) >> 4);
    p1_k2_r   <= 28'((33'(k_sq) + 33'd8) >> 4);
    p1_c_r    <= fr.c;
    p1_cos2_r <= fr.cos2;
    p1_sin2_r <= fr.sin2;
  end

  // Stage 2: d = eta2 - k2 - sin2, and eta2*k2
  logic               p2_vld_r;
  logic signed [29:0] p2_d_r;
  logic [55:0]        p2_ek_r;
  logic [CW-1:0]      p2_c_r, p2_cos2_r, p2_sin2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) p2_vld_r <= 1'b0;
    else p2_vld_r <= p1_vld_r;
    p2_d_r    <= $signed({2'b0, p1_eta2_r}) - $signed({2'b0, p1_k2_r})
                 - $signed({9'b0, p1_sin2_r});
    p2_ek_r   <= p1_eta2_r * p1_k2_r;
    p2_c_r    <= p1_c_r;
    p2_cos2_r <= p1_cos2_r;
    p2_sin2_r <= p1_sin2_r;
  end

  // Stage 3: d squared
  logic        p3_vld_r;
  logic [57:0] p3_adsq_r;
  logic [55:0] p3_ek_r;
  sd1_t        p3_side_r;
  logic [29:0] p2_mag;
  logic [28:0] p2_ad;

  assign p2_mag = p2_d_r[29] ? 30'(-p2_d_r) : 30'(p2_d_r);
  assign p2_ad  = p2_mag[28:0];

  always_ff @(posedge clk) begin
    if (!rst_n) p3_vld_r <= 1'b0;
    else p3_vld_r <= p2_vld_r;
    p3_adsq_r <= p2_ad * p2_ad;
    p3_ek_r   <= p2_ek_r;
    p3_side_r <= '{d: p2_d_r, c: p2_c_r, cos2: p2_cos2_r, sin2: p2_sin2_r};
  end

  // Square root of d^2 + 4 eta^2 k^2 (Q.40 -> Q.20), one root bit per stage
  logic             s1_vld  [0:R1];
  logic [2*R1-1:0]  s1_arg  [0:R1];
  logic [RW1-1:0]   s1_rem  [0:R1];
  logic [R1-1:0]    s1_root [0:R1];
  sd1_t             s1_side [0:R1];

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld[0] <= 1'b0;
    else s1_vld[0] <= p3_vld_r;
    s1_arg[0]  <= {2'b0, p3_adsq_r} + {2'b0, p3_ek_r, 2'b0};
    s1_rem[0]  <= '0;
    s1_root[0] <= '0;
    s1_side[0] <= p3_side_r;
  end

  for (genvar j = 0; j < R1; j++) begin : g_sq1
    logic [RW1-1:0] sh, trial;
    logic           take;
    assign sh    = {s1_rem[j][RW1-3:0], s1_arg[j][2*R1-1-2*j -: 2]};
    assign trial = {(RW1-2)'(s1_root[j]), 2'b01};
    assign take  = (sh >= trial);
    always_ff @(posedge clk) begin
      if (!rst_n) s1_vld[j+1] <= 1'b0;
      else s1_vld[j+1] <= s1_vld[j];
      s1_arg[j+1]  <= s1_arg[j];
      s1_rem[j+1]  <= take ? (sh - trial) : sh;
      s1_root[j+1] <= {s1_root[j][R1-2:0], take};
      s1_side[j+1] <= s1_side[j];
    end
  end

  // a^2 = max(S + d, 0) / 2, then root of a^2 in Q.40
  logic               s2_vld  [0:R2];
  logic [2*R2-1:0]    s2_arg  [0:R2];
  logic [RW2-1:0]     s2_rem  [0:R2];
  logic [R2-1:0]      s2_root [0:R2];
  sd2_t               s2_side [0:R2];
  logic signed [31:0] a2s;
  logic [29:0]        a2;

  assign a2s = $signed({2'b0, s1_root[R1]}) + 32'(s1_side[R1].d);
  assign a2  = a2s[31] ? 30'd0 : a2s[30:1];

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld[0] <= 1'b0;
    else s2_vld[0] <= s1_vld[R1];
    s2_arg[0]  <= {a2, 20'b0};
    s2_rem[0]  <= '0;
    s2_root[0] <= '0;
    s2_side[0] <= '{s: s1_root[R1], c: s1_side[R1].c, cos2: s1_side[R1].cos2,
                    sin2: s1_side[R1].sin2};
  end

  for (genvar j = 0; j < R2; j++) begin : g_sq2
    logic [RW2-1:0] sh, trial;
    logic           take;
    assign sh    = {s2_rem[j][RW2-3:0], s2_arg[j][2*R2-1-2*j -: 2]};
    assign trial = {(RW2-2)'(s2_root[j]), 2'b01};
    assign take  = (sh >= trial);
    always_ff @(posedge clk) begin
      if (!rst_n) s2_vld[j+1] <= 1'b0;
      else s2_vld[j+1] <= s2_vld[j];
      s2_arg[j+1]  <= s2_arg[j];
      s2_rem[j+1]  <= take ? (sh - trial) : sh;
      s2_root[j+1] <= {s2_root[j][R2-2:0], take};
      s2_side[j+1] <= s2_side[j];
    end
  end

  // Stage 6: u = 2ac, t1 = S + c^2
  logic          p6_vld_r;
  logic [26:0]   p6_u_r;
  logic [30:0]   p6_t1_r;
  logic [29:0]   p6_s_r;
  logic [CW-1:0] p6_cos2_r, p6_sin2_r;
  logic [46:0]   u_prod;

  assign u_prod = {s2_root[R2], 1'b0} * s2_side[R2].c;

  always_ff @(posedge clk) begin
    if (!rst_n) p6_vld_r <= 1'b0;
    else p6_vld_r <= s2_vld[R2];
    p6_u_r    <= 27'((u_prod + 47'(1 << (WB - 1))) >> WB);
    p6_t1_r   <= {1'b0, s2_side[R2].s} + 31'(s2_side[R2].cos2);
    p6_s_r    <= s2_side[R2].s;
    p6_cos2_r <= s2_side[R2].cos2;
    p6_sin2_r <= s2_side[R2].sin2;
  end

  // Stage 7: Rp-term products, first quotient operands
  logic        p7_vld_r;
  logic [30:0] p7_sc_r;
  logic [21:0] p7_ss_r;
  logic [27:0] p7_v_r;
  logic [31:0] p7_den1_r, p7_num1_r;
  logic [50:0] sc_prod;
  logic [41:0] ss_prod;
  logic [47:0] v_prod;

  assign sc_prod = p6_s_r * p6_cos2_r;
  assign ss_prod = p6_sin2_r * p6_sin2_r;
  assign v_prod  = p6_u_r * p6_sin2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) p7_vld_r <= 1'b0;
    else p7_vld_r <= p6_vld_r;
    p7_sc_r   <= 31'((sc_prod + 51'(1 << (WB - 1))) >> WB);
    p7_ss_r   <= 22'((ss_prod + 42'(1 << (WB - 1))) >> WB);
    p7_v_r    <= 28'((v_prod + 48'(1 << (WB - 1))) >> WB);
    p7_den1_r <= 32'(p6_t1_r) + 32'(p6_u_r);
    p7_num1_r <= (32'(p6_t1_r) >= 32'(p6_u_r)) ? 32'(p6_t1_r) - 32'(p6_u_r) : 32'd0;
  end

  // Stage 8: t2
  logic        p8_vld_r;
  logic [31:0] p8_t2_r, p8_den1_r, p8_num1_r;
  logic [27:0] p8_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) p8_vld_r <= 1'b0;
    else p8_vld_r <= p7_vld_r;
    p8_t2_r   <= 32'(p7_sc_r) + 32'(p7_ss_r);
    p8_v_r    <= p7_v_r;
    p8_den1_r <= p7_den1_r;
    p8_num1_r <= p7_num1_r;
  end

  // Stage 9: second quotient operands
  logic        p9_vld_r;
  logic [31:0] p9_den1_r, p9_num1_r, p9_den2_r, p9_num2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) p9_vld_r <= 1'b0;
    else p9_vld_r <= p8_vld_r;
    p9_den1_r <= p8_den1_r;
    p9_num1_r <= p8_num1_r;
    p9_den2_r <= p8_t2_r + 32'(p8_v_r);
    p9_num2_r <= (p8_t2_r >= 32'(p8_v_r)) ? p8_t2_r - 32'(p8_v_r) : 32'd0;
  end

  // Two restoring dividers, Q.30 quotient rounded half up, one bit per stage
  logic        dv_vld  [0:DQ];
  logic        dv_zero [0:DQ];
  logic [31:0] dv_den  [0:1][0:DQ];
  logic [31:0] dv_rem  [0:1][0:DQ];
  logic [30:0] dv_nlo  [0:1][0:DQ];
  logic [30:0] dv_q    [0:1][0:DQ];
  logic [63:0] dividend [0:1];
  logic [31:0] den_in   [0:1];

  assign den_in[0]   = p9_den1_r;
  assign den_in[1]   = p9_den2_r;
  assign dividend[0] = {p9_num1_r, 30'b0} + 64'(p9_den1_r >> 1);
  assign dividend[1] = {p9_num2_r, 30'b0} + 64'(p9_den2_r >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) dv_vld[0] <= 1'b0;
    else dv_vld[0] <= p9_vld_r;
    dv_zero[0] <= (p9_den1_r == 32'd0) || (p9_den2_r == 32'd0);
  end

  for (genvar k = 0; k < 2; k++) begin : g_div
    always_ff @(posedge clk) begin
      dv_den[k][0] <= den_in[k];
      dv_rem[k][0] <= dividend[k][62:31];
      dv_nlo[k][0] <= dividend[k][30:0];
      dv_q[k][0]   <= '0;
    end
    for (genvar j = 0; j < DQ; j++) begin : g_step
      logic [32:0] sh;
      logic        take;
      assign sh   = {dv_rem[k][j], dv_nlo[k][j][DQ-1-j]};
      assign take = (sh >= {1'b0, dv_den[k][j]});
      always_ff @(posedge clk) begin
        dv_den[k][j+1] <= dv_den[k][j];
        dv_nlo[k][j+1] <= dv_nlo[k][j];
        dv_rem[k][j+1] <= take ? 32'(sh - {1'b0, dv_den[k][j]}) : sh[31:0];
        dv_q[k][j+1]   <= {dv_q[k][j][DQ-2:0], take};
      end
    end
  end

  for (genvar j = 0; j < DQ; j++) begin : g_dvctl
    always_ff @(posedge clk) begin
      if (!rst_n) dv_vld[j+1] <= 1'b0;
      else dv_vld[j+1] <= dv_vld[j];
      dv_zero[j+1] <= dv_zero[j];
    end
  end

  // Stage 11: Rp = Rs * ratio
  logic        p11_vld_r, p11_zero_r;
  logic [30:0] p11_rs_r;
  logic [31:0] p11_rp_r;
  logic [61:0] rp_prod;

  assign rp_prod = dv_q[0][DQ] * dv_q[1][DQ];

  always_ff @(posedge clk) begin
    if (!rst_n) p11_vld_r <= 1'b0;
    else p11_vld_r <= dv_vld[DQ];
    p11_zero_r <= dv_zero[DQ];
    p11_rs_r   <= dv_q[0][DQ];
    p11_rp_r   <= 32'((rp_prod + 62'(1 << (QB - 1))) >> QB);
  end

  // Stage 12: mean, round to output format, saturate
  logic [32:0] mean_sum, mean_q30, rnd;

  assign mean_sum = 33'(p11_rs_r) + 33'(p11_rp_r) + 33'd1;
  assign mean_q30 = mean_sum >> 1;
  assign rnd      = (mean_q30 + RND_OUT) >> SH;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_o <= 1'b0;
    else vld_o <= p11_vld_r;
    if (p11_zero_r || rnd > ONE) refl_o <= ONE[15:0];
    else refl_o <= rnd[15:0];
  end

  // Roots come out as floor square roots
  a_sq1_floor: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld[R1] |-> (64'(s1_root[R1]) * 64'(s1_root[R1]) <= 64'(s1_arg[R1]))
      && ((64'(s1_root[R1]) + 64'd1) * (64'(s1_root[R1]) + 64'd1) > 64'(s1_arg[R1])))
    else $error("S root out of range");

  a_sq2_floor: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld[R2] |-> (64'(s2_root[R2]) * 64'(s2_root[R2]) <= 64'(s2_arg[R2]))
      && ((64'(s2_root[R2]) + 64'd1) * (64'(s2_root[R2]) + 64'd1) > 64'(s2_arg[R2])))
    else $error("a root out of range");

  // Quotient fits its bits: leading remainder below the divisor
  a_div_fit: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_vld[0] && !dv_zero[0]) |->
      (dv_rem[0][0] < dv_den[0][0]) && (dv_rem[1][0] < dv_den[1][0]))
    else $error("divider overflow");

endmodule
`default_nettype wire

// ===== rtl/conductor_fresnel_reflectance.sv =====
`default_nettype none
// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+---------------------------
// request   | start, busy, in_cos_incidence           | start && !busy
// result    | out_valid, out_refl_red/green/blue      | one-cycle strobe
// config    | cfg_we, cfg_index, cfg_data             | write when cfg_we high
//
// One request per cycle; busy is always low. Results come out in request order
// through the two square-root pipelines (30 and 25 stages) and the 31-stage
// quotient pipelines of each channel.
// rst_n (synchronous) clears the valid bits and loads the register defaults.
// The pipeline never stalls: results are strobed and must be taken.
module conductor_fresnel_reflectance #(
  parameter int CHANNELS  = 3,
  parameter int FRAC_BITS = 15
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] in_cos_incidence,
  output logic             out_valid,
  output logic [15:0]      out_refl_red,
  output logic [15:0]      out_refl_green,
  output logic [15:0]      out_refl_blue,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import cfr_pkg::*;

  localparam int unsigned NBUILT = (CHANNELS < NREG) ? CHANNELS : NREG;
  localparam int unsigned LAT = CH_LAT + 2;
  localparam logic [24:0] ONE_IN = 25'd1 << FRAC_BITS;
  localparam logic [47:0] RND_IN = 48'd1 << (FRAC_BITS - 1);
  localparam logic [16:0] ONE_OUT = 17'((33'd1 << FRAC_BITS) > 33'h1FFFF ?
                                        33'h1FFFF : (33'd1 << FRAC_BITS));

  // Configuration registers
  logic [15:0] eta_r    [0:NREG-1];
  logic [15:0] absorb_r [0:NREG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NREG; i++) begin
        eta_r[i]    <= 16'd4096;
        absorb_r[i] <= 16'd0;
      end
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ETA_RED:      eta_r[0]    <= cfg_data;
        CFG_ETA_GREEN:    eta_r[1]    <= cfg_data;
        CFG_ETA_BLUE:     eta_r[2]    <= cfg_data;
        CFG_ABSORB_RED:   absorb_r[0] <= cfg_data;
        CFG_ABSORB_GREEN: absorb_r[1] <= cfg_data;
        CFG_ABSORB_BLUE:  absorb_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Stage 1: saturate cosine, convert to Q.20
  logic          t1_vld_r;
  logic [CW-1:0] t1_c_r;
  logic [24:0]   cos_cl;
  logic [47:0]   cos_x;

  assign cos_cl = ({9'b0, in_cos_incidence} > ONE_IN) ? ONE_IN : {9'b0, in_cos_incidence};
  assign cos_x  = ({23'b0, cos_cl} << WB) + RND_IN;

  always_ff @(posedge clk) begin
    if (!rst_n) t1_vld_r <= 1'b0;
    else t1_vld_r <= start && !busy;
    t1_c_r <= CW'(cos_x >> FRAC_BITS);
  end

  // Stage 2: c^2 and 1 - c^2
  front_t      fr_r;
  logic [41:0] c_sq;
  logic [21:0] cos2_raw;
  logic [CW-1:0] cos2;

  assign c_sq     = t1_c_r * t1_c_r;
  assign cos2_raw = 22'((c_sq + 42'(1 << (WB - 1))) >> WB);
  assign cos2     = (cos2_raw > 22'(1 << WB)) ? CW'(1 << WB) : cos2_raw[CW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) fr_r.vld <= 1'b0;
    else fr_r.vld <= t1_vld_r;
    fr_r.c    <= t1_c_r;
    fr_r.cos2 <= cos2;
    fr_r.sin2 <= CW'(1 << WB) - cos2;
  end

  // Per-channel pipelines
  logic [NREG-1:0] ch_vld;
  logic [15:0]     refl [0:NREG-1];

  for (genvar g = 0; g < NREG; g++) begin : g_ch
    if (g < NBUILT) begin : g_on
      cfr_channel #(.FRAC_BITS(FRAC_BITS)) u_ch (
        .clk    (clk),
        .rst_n  (rst_n),
        .fr     (fr_r),
        .eta    (eta_r[g]),
        .absorb (absorb_r[g]),
        .vld_o  (ch_vld[g]),
        .refl_o (refl[g])
      );
    end else begin : g_off
      assign ch_vld[g] = 1'b0;
      assign refl[g]   = 16'd0;
    end
  end

  assign out_valid      = ch_vld[0];
  assign out_refl_red   = refl[0];
  assign out_refl_green = refl[1];
  assign out_refl_blue  = refl[2];

  // A result only follows a request that was taken earlier
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without request");

  // Reflectance never exceeds one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_refl_red} <= ONE_OUT) && ({1'b0, out_refl_green} <= ONE_OUT)
      && ({1'b0, out_refl_blue} <= ONE_OUT))
    else $error("reflectance above one");

  // An unbuilt blue channel reports zero
  a_unbuilt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (NBUILT < NREG)) |-> (out_refl_blue == 16'd0))
    else $error("unbuilt channel nonzero");

endmodule
`default_nettype wire

// ===== tb/cfr_checker.sv =====
module cfr_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [15:0] in_cos_incidence,
  input  wire logic        out_valid,
  input  wire logic [15:0] out_refl_red,
  input  wire logic [15:0] out_refl_green,
  input  wire logic [15:0] out_refl_blue,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output int               pending,
  output int               fail_count
);
  import cfr_pkg::*;

  localparam int FRAC = 15;
  localparam logic [63:0] ONE_OUT = 64'd1 << FRAC;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } refl_t;

  logic [15:0] eta_q[3];
  logic [15:0] absorb_q[3];
  refl_t       refl_queue[$];

  // Floor square root, bit by bit
  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Q.20 product, round half up
  function automatic logic [63:0] mul_q20(logic [63:0] x, logic [63:0] y);
    return (x * y + (64'd1 << (WB - 1))) >> WB;
  endfunction

  // Q.30 quotient, negative numerator clamped
  function automatic logic [63:0] quot_q30(longint num, longint den);
    logic [63:0] n;
    logic [63:0] dd;
    n  = (num < 0) ? 64'd0 : 64'(num);
    dd = 64'(den);
    return ((n << QB) + (dd >> 1)) / dd;
  endfunction

  function automatic logic [15:0] channel_refl(logic [63:0] c, logic [63:0] cos2,
                                               logic [63:0] sin2, logic [63:0] eta,
                                               logic [63:0] kk);
    logic [63:0] eta2, k2, ad, s, a2, a, u, rs, rp, r;
    longint d, a2s, t1, den1, t2, v, den2;
    eta2 = (eta * eta + 8) >> 4;
    k2   = (kk * kk + 8) >> 4;
    d    = longint'(eta2) - longint'(k2) - longint'(sin2);
    ad   = (d < 0) ? 64'(-d) : 64'(d);
    s    = floor_sqrt(ad * ad + 4 * eta2 * k2);
    a2s  = longint'(s) + d;
    a2   = (a2s < 0) ? 64'd0 : (64'(a2s) >> 1);
    a    = floor_sqrt(a2 << WB);
    u    = mul_q20(2 * a, c);
    t1   = longint'(s + cos2);
    den1 = t1 + longint'(u);
    if (den1 == 0) return ONE_OUT[15:0];
    t2   = longint'(mul_q20(s, cos2) + mul_q20(sin2, sin2));
    v    = longint'(mul_q20(u, sin2));
    den2 = t2 + v;
    if (den2 == 0) return ONE_OUT[15:0];
    rs = quot_q30(t1 - longint'(u), den1);
    rp = (rs * quot_q30(t2 - v, den2) + (64'd1 << (QB - 1))) >> QB;
    r  = (rs + rp + 1) >> 1;
    r  = (r + (64'd1 << (QB - FRAC - 1))) >> (QB - FRAC);
    if (r > ONE_OUT) r = ONE_OUT;
    return r[15:0];
  endfunction

  function automatic refl_t predict_refl(logic [15:0] cosq_in);
    logic [63:0] cosq, c, cos2, sin2;
    refl_t res;
    cosq = 64'(cosq_in);
    if (cosq > ONE_OUT) cosq = ONE_OUT;
    c    = ((cosq << WB) + (64'd1 << (FRAC - 1))) >> FRAC;
    cos2 = mul_q20(c, c);
    if (cos2 > (64'd1 << WB)) cos2 = 64'd1 << WB;
    sin2 = (64'd1 << WB) - cos2;
    res.red   = channel_refl(c, cos2, sin2, eta_q[0], absorb_q[0]);
    res.green = channel_refl(c, cos2, sin2, eta_q[1], absorb_q[1]);
    res.blue  = channel_refl(c, cos2, sin2, eta_q[2], absorb_q[2]);
    return res;
  endfunction

  assign pending = refl_queue.size();

  always @(posedge clk) begin
    refl_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        eta_q[i]    <= 16'd4096;
        absorb_q[i] <= 16'd0;
      end
      refl_queue.delete();
      fail_count <= 0;
    end else begin
      // compare first, then queue the new request
      if (out_valid) begin
        got = '{out_refl_red, out_refl_green, out_refl_blue};
        if (refl_queue.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result r=%0d g=%0d b=%0d",
                     got.red, got.green, got.blue);
          fail_count <= fail_count + 1;
        end else begin
          want = refl_queue.pop_front();
          if (got != want) begin
            if (fail_count < 10)
              $display("mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       want.red, want.green, want.blue, got.red, got.green, got.blue);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) refl_queue.push_back(predict_refl(in_cos_incidence));
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ETA_RED:      eta_q[0]    <= cfg_data;
          CFG_ETA_GREEN:    eta_q[1]    <= cfg_data;
          CFG_ETA_BLUE:     eta_q[2]    <= cfg_data;
          CFG_ABSORB_RED:   absorb_q[0] <= cfg_data;
          CFG_ABSORB_GREEN: absorb_q[1] <= cfg_data;
          CFG_ABSORB_BLUE:  absorb_q[2] <= cfg_data;
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import cfr_pkg::*;

  localparam logic [2:0] CFG_SPARE_LO = 3'd6;  // no register behind these
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;
  localparam int DRAIN_CYCLES = 120;
  localparam int STALL_LIMIT  = 3000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [15:0] in_cos_incidence;
  logic        out_valid;
  logic [15:0] out_refl_red, out_refl_green, out_refl_blue;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  int          pending, fail_count, stall_cnt;
  bit          calm;

  conductor_fresnel_reflectance u_top (.*);

  cfr_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Watchdog: cycles with nothing accepted
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("conductor_fresnel_reflectance regression: fail");
      $finish;
    end
  end

  // Present one request and hold it until taken; returns at the accepting edge
  task automatic send_cos(logic [15:0] val);
    bit ok;
    start            <= 1'b1;
    in_cos_incidence <= val;
    forever begin
      @(negedge clk);
      ok = !busy;
      @(posedge clk);
      if (ok) break;
    end
  endtask

  // Random burst of idle cycles between requests
  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One write per edge; the enable stays up until write_done
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic write_done();
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_reg_val();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd4096;
      3: return 16'($urandom_range(0, 16384));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_cos();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return 16'($urandom_range(32760, 32768));
      2: return 16'($urandom_range(0, 8));
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  task automatic all_regs(logic [15:0] eta, logic [15:0] k);
    write_reg(CFG_ETA_RED, eta);
    write_reg(CFG_ETA_GREEN, eta);
    write_reg(CFG_ETA_BLUE, eta);
    write_reg(CFG_ABSORB_RED, k);
    write_reg(CFG_ABSORB_GREEN, k);
    write_reg(CFG_ABSORB_BLUE, k);
  endtask

  task automatic directed_sweep();
    logic [15:0] pts[8] = '{16'd0, 16'd1, 16'd16384, 16'd32767, 16'd32768,
                            16'd32769, 16'hFFFF, 16'h5555};
    foreach (pts[i]) begin
      send_cos(pts[i]);
      maybe_gap();
    end
  endtask

  initial begin
    rst_n = 0; start = 0; in_cos_incidence = 0;
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    calm = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: defaults, then extreme registers
    directed_sweep();
    drain();
    all_regs(16'd0, 16'd0);
    write_done();
    directed_sweep();
    drain();
    all_regs(16'hFFFF, 16'hFFFF);
    write_reg(CFG_SPARE_LO, 16'd1);
    write_reg(CFG_SPARE_HI, 16'hAAAA);
    write_done();
    directed_sweep();
    drain();

    // Random phases with new settings each time
    for (int ph = 0; ph < 6; ph++) begin
      for (int r = 0; r < 8; r++) write_reg(3'($urandom_range(0, 7)), pick_reg_val());
      write_done();
      for (int i = 0; i < 75; i++) begin
        if (ph == 5 && i >= 40) calm = 1;
        send_cos(pick_cos());
        maybe_gap();
      end
      drain();
    end

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("conductor_fresnel_reflectance regression: pass");
    end else begin
      $display("conductor_fresnel_reflectance regression: fail");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/cfr_pkg.sv
rtl/cfr_channel.sv
rtl/conductor_fresnel_reflectance.sv
tb/cfr_checker.sv
tb/tb_top.sv
